[rtl/ffbh_pkg.sv]
`timescale 1ns / 1ps
// ffbh_pkg: shared types, codes and constants for the first-fit block heap allocator.
// No dependencies; every other file references this package by scoped names.
package ffbh_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 12;

    // Configuration register reset values and the size of the first block
    localparam logic [31:0] RESET_HEAP_START = 32'h0010_2000;
    localparam logic [31:0] RESET_HEAP_END   = 32'h0020_0000;
    localparam logic [31:0] INIT_BLOCK_BYTES = 32'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 1'b1;

    // Operation codes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO       = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] request_bytes;
        logic [31:0] buffer_address;
    } t_in_word;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [2:0]  status;
    } t_out_word;

    // One block table entry
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] bytes;
        logic        is_free;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic init;      // rebuild the heap (boot)
        logic accept;    // capture the input word
        logic start;     // first cycle of an operation
        logic scan;      // step the table scan
        logic commit;    // apply the decision on the evaluated entry
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan; // operation walks the table
        logic ev_valid;  // an entry is under evaluation
        logic decide;    // the evaluated entry ends the scan
    } t_dp_status;

endpackage

[rtl/first_fit_block_heap_allocator.sv]
`timescale 1ns / 1ps
// first_fit_block_heap_allocator: first-fit heap manager over a bounded block table.
// Sequence: init, unused op and zero-size alloc go accept, start, then result word;
//   alloc and free go accept, start, table scan (one table entry read per cycle), result.
// Throughput: one word in flight; the next word is taken once the result is registered.
// Reset: synchronous, active low; a boot state then writes the first table entry
//   (input stalled meanwhile), config writes are taken at any time.
module first_fit_block_heap_allocator #(
    parameter int MAX_BLOCKS   = ffbh_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffbh_pkg::DEF_HEADER_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request words
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ffbh_pkg::t_in_word             i_in_word,
    // result words
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ffbh_pkg::t_out_word            o_out_word,
    // config writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffbh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    ffbh_pkg::t_dp_cmd    dp_cmd;
    ffbh_pkg::t_dp_status dp_status;

    // Config registers are plain flops, always writable. A new heap start takes
    // effect at the next init word, a new heap end at the next operation's start.
    assign o_cfg_ready = 1'b1;

    // Sequencer: boot, accept, start, table scan, result hand-off.
    ffbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Datapath: the table memory is scanned in creation order with a one-deep read pipeline;
    // the first deciding entry is acted on in the commit cycle (updated, or appended after).
    ffbh_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

[rtl/ffbh_ctrl.sv]
`timescale 1ns / 1ps
// ffbh_ctrl: operation sequencer for the heap allocator.
// Depends on ffbh_pkg; drives ffbh_dp through t_dp_cmd and reads t_dp_status.
module ffbh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ffbh_pkg::t_dp_status i_status,
    output ffbh_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_START,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_BOOT: begin
                o_cmd.init = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_status.need_scan ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.ev_valid && i_status.decide) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_RESULT;
                end
            end
            S_RESULT: begin
                // output register free, or its word leaves this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[rtl/ffbh_dp.sv]
`timescale 1ns / 1ps
// ffbh_dp: block table memory, heap pointers, config registers and result path.
// Depends on ffbh_pkg; sequenced by ffbh_ctrl.
module ffbh_dp #(
    parameter int MAX_BLOCKS   = ffbh_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffbh_pkg::DEF_HEADER_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffbh_pkg::t_dp_cmd                  i_cmd,
    output ffbh_pkg::t_dp_status               o_status,
    input  ffbh_pkg::t_in_word                 i_in_word,
    output ffbh_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [ffbh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR32 = 32'(((HEADER_BYTES + 3) / 4) * 4);

    // config
    logic [31:0] r_heap_start, r_heap_end;

    // operation context
    logic [1:0]  r_op;
    logic [31:0] r_req, r_buf;
    logic [32:0] r_areq;
    logic [33:0] r_need_app;
    logic [31:0] r_room;

    // heap state
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_bump, n_bump;

    // table memory and scan pipeline
    ffbh_pkg::t_entry mem [MAX_BLOCKS];
    ffbh_pkg::t_entry r_rd_data;
    logic [CW-1:0]    r_rd_idx, r_ev_idx;
    logic             r_ev_valid;

    // results
    ffbh_pkg::t_out_word r_res, r_out;

    // combinational
    ffbh_pkg::t_entry ev;
    logic [32:0] ev_asz, grow_need, shrink_amt;
    logic        ev_last, ev_match, grow, is_init, need_scan, decide;
    logic [31:0] ev_buf, init_bump;
    logic        we;
    logic [IDXW-1:0] waddr;
    ffbh_pkg::t_entry wdata;
    logic [31:0] c_addr;
    logic [2:0]  c_status;

    assign ev         = r_rd_data;
    assign ev_asz     = ({1'b0, ev.bytes} + 33'd3) & ~33'd3;
    assign ev_last    = (r_ev_idx == r_count - CW'(1));
    assign ev_buf     = ev.start + HDR32;
    assign ev_match   = (ev_buf == r_buf);
    assign grow       = (r_areq > ev_asz);
    assign grow_need  = r_areq - ev_asz;
    assign shrink_amt = ev_asz - r_areq;
    assign init_bump  = r_heap_start + HDR32 + ffbh_pkg::INIT_BLOCK_BYTES;
    assign is_init    = i_cmd.init || (i_cmd.start && (r_op == ffbh_pkg::OP_INIT));
    assign need_scan  = ((r_op == ffbh_pkg::OP_ALLOC) && (r_req != 32'd0))
                        || (r_op == ffbh_pkg::OP_FREE);

    always_comb begin
        case (r_op)
            ffbh_pkg::OP_ALLOC: decide = ev.is_free ? (ev_last || (ev_asz >= r_areq)) : ev_last;
            ffbh_pkg::OP_FREE:  decide = ev_match || ev_last;
            default:            decide = 1'b1;
        endcase
    end

    assign o_status.need_scan = need_scan;
    assign o_status.ev_valid  = r_ev_valid;
    assign o_status.decide    = decide;

    // decision on the evaluated entry, applied on commit; init rewrites the first entry
    always_comb begin
        we       = 1'b0;
        waddr    = r_ev_idx[IDXW-1:0];
        wdata    = ev;
        n_count  = r_count;
        n_bump   = r_bump;
        c_addr   = 32'd0;
        c_status = ffbh_pkg::ST_OK;
        if (is_init) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = '{start: r_heap_start, bytes: ffbh_pkg::INIT_BLOCK_BYTES, is_free: 1'b1};
            n_count = CW'(1);
            n_bump  = init_bump;
        end else if (i_cmd.commit) begin
            case (r_op)
                ffbh_pkg::OP_ALLOC: begin
                    if (ev.is_free && ev_last) begin
                        // last block: regrow or shrink in place
                        if (grow && (grow_need > {1'b0, r_room})) begin
                            c_status = ffbh_pkg::ST_EXHAUSTED;
                        end else begin
                            n_bump = grow ? r_bump + grow_need[31:0]
                                          : r_bump - shrink_amt[31:0];
                            we     = 1'b1;
                            wdata  = '{start: ev.start, bytes: r_req, is_free: 1'b0};
                            c_addr = ev_buf;
                        end
                    end else if (ev.is_free) begin
                        we     = 1'b1;
                        wdata  = '{start: ev.start, bytes: ev.bytes, is_free: 1'b0};
                        c_addr = ev_buf;
                    end else begin
                        // last block in use: append a new one
                        if (r_count == CW'(MAX_BLOCKS)) begin
                            c_status = ffbh_pkg::ST_TABLE_FULL;
                        end else if (r_need_app > {2'b00, r_room}) begin
                            c_status = ffbh_pkg::ST_EXHAUSTED;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[IDXW-1:0];
                            wdata   = '{start: r_bump, bytes: r_req, is_free: 1'b0};
                            n_count = r_count + CW'(1);
                            n_bump  = r_bump + r_need_app[31:0];
                            c_addr  = r_bump + HDR32;
                        end
                    end
                end
                ffbh_pkg::OP_FREE: begin
                    if (ev_match) begin
                        we    = 1'b1;
                        wdata = '{start: ev.start, bytes: ev.bytes, is_free: 1'b1};
                    end else begin
                        c_status = ffbh_pkg::ST_UNKNOWN;
                    end
                end
                default: begin
                    c_status = ffbh_pkg::ST_OK;
                end
            endcase
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[r_rd_idx[IDXW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= ffbh_pkg::RESET_HEAP_START;
            r_heap_end   <= ffbh_pkg::RESET_HEAP_END;
            r_count      <= CW'(1);
            r_bump       <= ffbh_pkg::RESET_HEAP_START + HDR32 + ffbh_pkg::INIT_BLOCK_BYTES;
            r_rd_idx     <= '0;
            r_ev_idx     <= '0;
            r_ev_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffbh_pkg::CFG_HEAP_START: r_heap_start <= i_cfg_data;
                    ffbh_pkg::CFG_HEAP_END:   r_heap_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_count <= n_count;
            r_bump  <= n_bump;
            if (i_cmd.start) begin
                r_rd_idx   <= '0;
                r_ev_valid <= 1'b0;
            end else if (i_cmd.commit) begin
                r_ev_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_idx   <= r_rd_idx + CW'(1);
                r_ev_idx   <= r_rd_idx;
                r_ev_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_word.op;
            r_req  <= i_in_word.request_bytes;
            r_buf  <= i_in_word.buffer_address;
            r_areq <= ({1'b0, i_in_word.request_bytes} + 33'd3) & ~33'd3;
        end
        if (i_cmd.start) begin
            r_need_app <= {1'b0, r_areq} + {2'b00, HDR32};
            r_room     <= (r_bump > r_heap_end) ? 32'd0 : r_heap_end - r_bump;
            if (!need_scan) begin
                r_res.granted_address <= 32'd0;
                r_res.status <= ((r_op == ffbh_pkg::OP_ALLOC) && (r_req == 32'd0))
                                ? ffbh_pkg::ST_ZERO : ffbh_pkg::ST_OK;
            end
        end
        if (i_cmd.commit) begin
            r_res.granted_address <= c_addr;
            r_res.status          <= c_status;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_word = r_out;

endmodule
